### src/pwd_pkg.sv
package pwd_pkg;

	localparam int COORD_WIDTH      = 20;
	localparam int WALK_W           = 20;
	localparam int SEG_W            = 8;
	localparam int MAX_VERTICES_DEF = 256;

	// magnitude of a coordinate difference, distance, root and product widths
	localparam int MAG_W     = COORD_WIDTH + 1;
	localparam int DIST_W    = (COORD_WIDTH + 2 > WALK_W) ? COORD_WIDTH + 2 : WALK_W;
	localparam int ROOT_BITS = MAG_W + 1;
	localparam int RT_W      = 2 * ROOT_BITS;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int PROD_W    = MAG_W + DIST_W;

	typedef enum logic [0:0] {
		CMD_APPEND = 1'b0,
		CMD_QUERY  = 1'b1
	} cmd_code_t;

	typedef struct packed {
		logic                          command;
		logic                          new_polyline;
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic [SEG_W-1:0]              origin_segment;
		logic                          toward_end;
		logic                          from_extreme;
		logic [WALK_W-1:0]             walk_distance;
	} walk_in_t;

	typedef struct packed {
		logic [SEG_W-1:0]              result_segment;
		logic signed [COORD_WIDTH-1:0] result_x;
		logic signed [COORD_WIDTH-1:0] result_y;
		logic                          reached_extreme;
		logic                          query_error;
	} walk_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SQX,
		ST_SQY,
		ST_SQRT,
		ST_DECIDE,
		ST_LMUL,
		ST_LDIV,
		ST_LFIN,
		ST_DONE
	} walk_state_t;

endpackage

### src/polyline_walk_by_distance_unit.sv
// Polyline distance walk.
// cmd channel (valid/ready): an append item writes one vertex into the store unless it is
// full with no new polyline, and gives no result; a query item walks the stored vertices
// from the origin and gives exactly one item on the res channel (valid/ready).
// A query with an error answer goes from idle straight to the done state; otherwise each
// visited vertex takes a memory read, two squares on one multiplier and a bit-serial
// square root of one bit a cycle, and an interpolation adds one multiply and a
// restoring divide per coordinate. Appends run one per cycle while the sequencer is idle.
// One item is worked on at a time; cmd_ready is high whenever the sequencer is idle,
// also while a finished result still waits in the output register.
// If the receiver stalls, the result is held in the output register and a following
// query waits at its end until the register is free.
// Reset empties the polyline (vertex count zero) and clears the output valid flag;
// the vertex memory itself is not cleared, only entries below the count are read.
module polyline_walk_by_distance_unit
	import pwd_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  walk_in_t  cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output walk_out_t res
);

	localparam int CW    = COORD_WIDTH;
	localparam int AW    = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int IW    = (CNT_W > SEG_W + 1) ? CNT_W : SEG_W + 1;
	localparam int CTR_W = $clog2(ROOT_BITS + 1);

	walk_state_t state_q, state_d;

	logic [2*CW-1:0] vtx_mem [MAX_VERTICES];
	logic [2*CW-1:0] rd_s1;
	logic            mem_we;
	logic [AW-1:0]   mem_wa;

	logic [CNT_W-1:0]       count_q;
	logic signed [CW-1:0]   ox_q, oy_q;
	logic [DIST_W-1:0]      d_q;
	logic [SEG_W-1:0]       seg_q;
	logic                   te_q, fe_q, first_q;
	logic [AW-1:0]          i_q;
	logic signed [CW-1:0]   vx_q, vy_q, pvx_q, pvy_q;
	logic [SQ_W-1:0]        sq_q;
	logic [RT_W-1:0]        op_q, root_q, one_q;
	logic [CTR_W-1:0]       cnt_q;
	logic [DIST_W-1:0]      prev_q;
	logic signed [CW-1:0]   lax_q, lay_q, lbx_q, lby_q;
	logic [DIST_W-1:0]      num_q, den_q;
	logic                   coord_q, neg_q;
	logic [DIST_W-1:0]      rem_q;
	logic [MAG_W-1:0]       dv_q;
	logic [IW-1:0]          rs_q;
	logic signed [CW-1:0]   px_q, py_q;
	logic                   reach_q, err_q;
	logic                   res_valid_q;
	walk_out_t              res_q;

	function automatic logic [MAG_W-1:0] mag_diff(logic signed [CW-1:0] a,
			logic signed [CW-1:0] b);
		logic signed [CW:0] df;
		df = {a[CW-1], a} - {b[CW-1], b};
		return df[CW] ? MAG_W'(-df) : MAG_W'(df);
	endfunction

	// handshake and query set-up
	logic           cmd_acc;
	logic [IW-1:0]  n_ext, seg_ext;
	logic           q_err;
	logic [AW-1:0]  i_init;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign n_ext   = IW'(count_q);
	assign seg_ext = IW'(cmd.origin_segment);
	assign q_err   = (n_ext < IW'(2)) || (!cmd.from_extreme && (seg_ext > n_ext - IW'(2)));

	always_comb begin
		priority if (cmd.from_extreme)
			i_init = cmd.toward_end ? AW'(0) : AW'(n_ext - IW'(1));
		else
			i_init = cmd.toward_end ? AW'(seg_ext + IW'(1)) : AW'(seg_ext);
	end

	// vertex memory
	assign mem_we = cmd_acc && (cmd.command == CMD_APPEND) &&
		(cmd.new_polyline || (n_ext < IW'(MAX_VERTICES)));
	assign mem_wa = cmd.new_polyline ? AW'(0) : AW'(count_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			vtx_mem[mem_wa] <= {cmd.point_x, cmd.point_y};
		rd_s1 <= vtx_mem[i_q];
	end

	// square root step, one result bit a cycle
	logic [RT_W-1:0] sq_try;
	logic            sq_ge;
	assign sq_try = root_q + one_q;
	assign sq_ge  = op_q >= sq_try;

	// walk decision
	logic [DIST_W-1:0] cur, den_c, num_c;
	logic              ge, at_end;
	logic [IW-1:0]     i_ext;
	assign cur    = DIST_W'(root_q);
	assign ge     = cur >= d_q;
	assign i_ext  = IW'(i_q);
	assign at_end = te_q ? (i_ext == n_ext - IW'(1)) : (i_q == AW'(0));
	assign den_c  = first_q ? cur : cur - prev_q;
	assign num_c  = first_q ? d_q : d_q - prev_q;

	// interpolation
	logic signed [CW-1:0] la_c, lb_c;
	logic signed [CW:0]   delta_c;
	logic [MAG_W-1:0]     dmag_c;
	logic [PROD_W-1:0]    prod_c;
	logic [DIST_W:0]      dtry;
	logic                 dge;
	logic signed [CW:0]   lres_c;
	assign la_c    = coord_q ? lay_q : lax_q;
	assign lb_c    = coord_q ? lby_q : lbx_q;
	assign delta_c = {lb_c[CW-1], lb_c} - {la_c[CW-1], la_c};
	assign dmag_c  = mag_diff(lb_c, la_c);
	assign prod_c  = PROD_W'(dmag_c) * PROD_W'(num_q);
	assign dtry    = {rem_q, dv_q[MAG_W-1]};
	assign dge     = dtry >= {1'b0, den_q};
	assign lres_c  = neg_q ? ({la_c[CW-1], la_c} - $signed({1'b0, dv_q[CW-1:0]}))
	                       : ({la_c[CW-1], la_c} + $signed({1'b0, dv_q[CW-1:0]}));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && cmd.command == CMD_QUERY)
					state_d = q_err ? ST_DONE : ST_FETCH;
			end
			ST_FETCH:  state_d = ST_SQX;
			ST_SQX:    state_d = ST_SQY;
			ST_SQY:    state_d = ST_SQRT;
			ST_SQRT: begin
				if (cnt_q == CTR_W'(ROOT_BITS - 1))
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				priority if (ge) begin
					priority if (first_q && fe_q)
						state_d = ST_DONE;
					else if (den_c == '0)
						state_d = ST_DONE;
					else
						state_d = ST_LMUL;
				end else if (at_end)
					state_d = ST_DONE;
				else
					state_d = ST_FETCH;
			end
			ST_LMUL:   state_d = ST_LDIV;
			ST_LDIV: begin
				if (cnt_q == CTR_W'(MAG_W - 1))
					state_d = ST_LFIN;
			end
			ST_LFIN:   state_d = coord_q ? ST_DONE : ST_LMUL;
			ST_DONE: begin
				if (!res_valid_q || res_ready)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// vertex count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_acc && cmd.command == CMD_APPEND) begin
				priority if (cmd.new_polyline)
					count_q <= CNT_W'(1);
				else if (n_ext < IW'(MAX_VERTICES))
					count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_DONE && (!res_valid_q || res_ready))
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!res_valid_q || res_ready)) begin
			res_q.result_segment  <= rs_q[SEG_W-1:0];
			res_q.result_x        <= px_q;
			res_q.result_y        <= py_q;
			res_q.reached_extreme <= reach_q;
			res_q.query_error     <= err_q;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ox_q    <= cmd.point_x;
				oy_q    <= cmd.point_y;
				d_q     <= DIST_W'(cmd.walk_distance);
				seg_q   <= cmd.origin_segment;
				te_q    <= cmd.toward_end;
				fe_q    <= cmd.from_extreme;
				first_q <= 1'b1;
				i_q     <= i_init;
				rs_q    <= '0;
				px_q    <= '0;
				py_q    <= '0;
				reach_q <= 1'b0;
				err_q   <= q_err;
			end
			ST_SQX: begin
				vx_q <= rd_s1[2*CW-1:CW];
				vy_q <= rd_s1[CW-1:0];
				sq_q <= SQ_W'(mag_diff(rd_s1[2*CW-1:CW], ox_q)) *
				        SQ_W'(mag_diff(rd_s1[2*CW-1:CW], ox_q));
			end
			ST_SQY: begin
				op_q   <= RT_W'(sq_q) + RT_W'(SQ_W'(mag_diff(vy_q, oy_q)) *
				          SQ_W'(mag_diff(vy_q, oy_q)));
				root_q <= '0;
				one_q  <= RT_W'(1) << (2 * (ROOT_BITS - 1));
				cnt_q  <= '0;
			end
			ST_SQRT: begin
				if (sq_ge) begin
					op_q   <= op_q - sq_try;
					root_q <= (root_q >> 1) + one_q;
				end else
					root_q <= root_q >> 1;
				one_q <= one_q >> 2;
				cnt_q <= cnt_q + CTR_W'(1);
			end
			ST_DECIDE: begin
				coord_q <= 1'b0;
				num_q   <= num_c;
				den_q   <= den_c;
				lbx_q   <= vx_q;
				lby_q   <= vy_q;
				priority if (ge) begin
					priority if (first_q) begin
						lax_q <= ox_q;
						lay_q <= oy_q;
						px_q  <= ox_q;
						py_q  <= oy_q;
						rs_q  <= IW'(seg_q);
						if (fe_q) begin
							px_q <= vx_q;
							py_q <= vy_q;
							rs_q <= te_q ? IW'(0) : n_ext - IW'(2);
						end
					end else begin
						lax_q <= pvx_q;
						lay_q <= pvy_q;
						px_q  <= pvx_q;
						py_q  <= pvy_q;
						rs_q  <= te_q ? i_ext - IW'(1) : i_ext;
					end
				end else if (at_end) begin
					reach_q <= 1'b1;
					px_q    <= vx_q;
					py_q    <= vy_q;
					rs_q    <= te_q ? n_ext - IW'(2) : IW'(0);
				end else begin
					prev_q  <= cur;
					pvx_q   <= vx_q;
					pvy_q   <= vy_q;
					first_q <= 1'b0;
					i_q     <= te_q ? i_q + AW'(1) : i_q - AW'(1);
				end
			end
			ST_LMUL: begin
				neg_q <= delta_c[CW];
				rem_q <= prod_c[PROD_W-1:MAG_W];
				dv_q  <= prod_c[MAG_W-1:0];
				cnt_q <= '0;
			end
			ST_LDIV: begin
				rem_q <= dge ? DIST_W'(dtry - {1'b0, den_q}) : DIST_W'(dtry);
				dv_q  <= {dv_q[MAG_W-2:0], dge};
				cnt_q <= cnt_q + CTR_W'(1);
			end
			ST_LFIN: begin
				if (coord_q)
					py_q <= lres_c[CW-1:0];
				else
					px_q <= lres_c[CW-1:0];
				coord_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### src/pwd_checker.sv
module pwd_checker
	import pwd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_ready,
	input walk_in_t  cmd,
	input logic      res_valid,
	input logic      res_ready,
	input walk_out_t res
);

	// a stalled result item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	// an error answer carries zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.query_error |-> res.result_x == '0 && res.result_y == '0 &&
		res.result_segment == '0 && !res.reached_extreme)
		else $error("error result with non-zero fields");

	// a taken query leaves the command side busy in the following cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.command == CMD_QUERY |=> !cmd_ready)
		else $error("command taken right after a query");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.reached_extreme && res.query_error))
		else $error("extreme and error flags both set");

endmodule

bind polyline_walk_by_distance_unit pwd_checker u_pwd_checker (.*);
